>>> sv/sha1md_pkg.sv
package sha1md_pkg;

	// Opcodes of an input transaction
	localparam logic [1:0] OP_ABSORB        = 2'd0;
	localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] OP_FINISH        = 2'd2;

	// Byte source for a buffer push
	localparam logic [1:0] SEL_IN   = 2'd0;
	localparam logic [1:0] SEL_PAD  = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	typedef logic [4:0][31:0] digest_t;

	localparam digest_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [3:0][31:0] ROUND_K = {32'hCA62C1D6, 32'h8F1BBCDC,
		32'h6ED9EBA1, 32'h5A827999};

	typedef struct packed {
		logic       push;
		logic [1:0] push_sel;
		logic       latch_len;
		logic       round;
		logic [1:0] phase;
		logic       add;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} stat_t;

endpackage

>>> sv/sha1md_in_if.sv
interface sha1md_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] message_byte;

	modport source (output valid, output opcode, output message_byte, input ready);
	modport sink (input valid, input opcode, input message_byte, output ready);
endinterface

>>> sv/sha1md_out_if.sv
interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, output digest_word4, input ready);
	modport sink (input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, input digest_word4, output ready);
endinterface

>>> sv/sha1md_dp.sv
module sha1md_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1md_pkg::cmd_t  cmd,
	input  logic [7:0]        in_byte,
	output sha1md_pkg::stat_t stat,
	output sha1md_pkg::digest_t digest
);
	import sha1md_pkg::*;

	logic [511:0] buf_q;
	digest_t      h_q;
	digest_t      dig_q;
	logic [63:0]  cnt_q;
	logic [63:0]  len_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;

	logic [5:0]   pos;
	logic [7:0]   push_byte;
	logic [31:0]  f;
	logic [31:0]  t;
	logic [31:0]  w_mix;
	logic [31:0]  w_new;

	assign pos      = cnt_q[8:3];
	assign stat.pos = pos;
	assign digest   = dig_q;

	always_comb begin
		case (cmd.push_sel)
			SEL_IN:   push_byte = in_byte;
			SEL_PAD:  push_byte = PAD_BYTE;
			SEL_ZERO: push_byte = 8'h00;
			SEL_LEN:  push_byte = len_q[{~pos[2:0], 3'b000} +: 8];
			default:  push_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (cmd.phase)
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd2:    f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
	end

	// Window word j of the schedule sits at buf_q[511-32*j -: 32]
	assign w_mix = buf_q[95:64] ^ buf_q[255:224] ^ buf_q[447:416] ^ buf_q[511:480];
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign t     = {a_q[26:0], a_q[31:27]} + f + e_q + ROUND_K[cmd.phase] + buf_q[511:480];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= H_INIT;
			cnt_q <= '0;
		end else if (cmd.finish) begin
			h_q   <= H_INIT;
			cnt_q <= '0;
		end else begin
			if (cmd.add) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.push) begin
				cnt_q <= cnt_q + 64'd8;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			buf_q <= {buf_q[503:0], push_byte};
			// last byte of a block: seed the working variables
			if (pos == LAST_POS) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end
		if (cmd.round) begin
			buf_q <= {buf_q[479:0], w_new};
			a_q   <= t;
			b_q   <= a_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			d_q   <= c_q;
			e_q   <= d_q;
		end
		if (cmd.latch_len) begin
			len_q <= cnt_q;
		end
		if (cmd.finish) begin
			dig_q <= h_q;
		end
	end
endmodule

>>> sv/sha1md_ctrl.sv
module sha1md_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_opcode,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sha1md_pkg::stat_t stat,
	output sha1md_pkg::cmd_t  cmd
);
	import sha1md_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD80 = 3'd1;
	localparam logic [2:0] ST_PAD   = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [6:0] rnd_q, rnd_d;
	logic       lenp_q, lenp_d;
	logic       ov_q, ov_d;
	logic       in_fire;
	logic       last_pos;
	logic       lenp_now;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = ov_q;
	assign last_pos  = (stat.pos == LAST_POS);
	assign lenp_now  = lenp_q || (stat.pos == LEN_POS);

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		rnd_d   = rnd_q;
		lenp_d  = lenp_q;
		ov_d    = ov_q && !out_ready;
		cmd     = '0;
		if (rnd_q < 7'd20) begin
			cmd.phase = 2'd0;
		end else if (rnd_q < 7'd40) begin
			cmd.phase = 2'd1;
		end else if (rnd_q < 7'd60) begin
			cmd.phase = 2'd2;
		end else begin
			cmd.phase = 2'd3;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (in_opcode)
						OP_ABSORB: begin
							cmd.push     = 1'b1;
							cmd.push_sel = SEL_IN;
							ret_d        = ST_IDLE;
							if (last_pos) begin
								state_d = ST_ROUND;
							end
						end
						OP_ABSORB_FINISH: begin
							cmd.push     = 1'b1;
							cmd.push_sel = SEL_IN;
							ret_d        = ST_PAD80;
							state_d      = last_pos ? ST_ROUND : ST_PAD80;
						end
						OP_FINISH: begin
							state_d = ST_PAD80;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PAD80: begin
				cmd.push      = 1'b1;
				cmd.push_sel  = SEL_PAD;
				cmd.latch_len = 1'b1;
				lenp_d        = 1'b0;
				ret_d         = ST_PAD;
				state_d       = last_pos ? ST_ROUND : ST_PAD;
			end
			ST_PAD: begin
				cmd.push     = 1'b1;
				cmd.push_sel = lenp_now ? SEL_LEN : SEL_ZERO;
				lenp_d       = lenp_now;
				if (last_pos) begin
					state_d = ST_ROUND;
					ret_d   = lenp_now ? ST_DONE : ST_PAD;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					rnd_d   = '0;
					state_d = ST_ADD;
				end else begin
					rnd_d = rnd_q + 7'd1;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ret_q;
			end
			ST_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.finish = 1'b1;
					ov_d       = 1'b1;
					lenp_d     = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
			lenp_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			rnd_q   <= rnd_d;
			lenp_q  <= lenp_d;
			ov_q    <= ov_d;
		end
	end
endmodule

>>> sv/sha1_message_digest_core.sv
// SHA-1 message digest engine, one message byte per input transaction.
// Channel msg carries opcode and message_byte: absorb a byte, absorb a byte
// and finish, or finish without a byte (opcode 3 is dropped without effect).
// Channel digest returns the 160-bit digest as five big-endian words after
// each finish; absorb-only transactions return nothing.
// Each absorbed byte goes into the block buffer, and every 64th byte starts
// the compression (80 rounds on one shared round unit, one per cycle,
// then the chaining add), while no new byte is accepted. A finish pushes
// the padding and length bytes one per cycle (9 to 72 bytes), pausing for
// one or two compressions, then loads the digest register.
// msg.ready is high only while the controller waits for a new transaction.
// The digest sits in an output register: if digest.ready stays low, new
// bytes are still accepted, and only the next finish holds until the
// pending digest has been taken.
// Reset (arst_n low) loads the initial chaining words, clears the bit
// count and drops any pending digest; the buffer needs no clearing.
module sha1_message_digest_core (
	input  logic         clk,
	input  logic         arst_n,
	sha1md_in_if.sink    msg,
	sha1md_out_if.source digest
);
	import sha1md_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	digest_t dig;

	// sequencer: byte intake, padding, round count and digest handoff
	sha1md_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_opcode (msg.opcode),
		.in_ready  (msg.ready),
		.out_valid (digest.valid),
		.out_ready (digest.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// block buffer, message schedule, round unit, chaining words, bit count
	sha1md_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_byte (msg.message_byte),
		.stat    (stat),
		.digest  (dig)
	);

	assign digest.digest_word0 = dig[0];
	assign digest.digest_word1 = dig[1];
	assign digest.digest_word2 = dig[2];
	assign digest.digest_word3 = dig[3];
	assign digest.digest_word4 = dig[4];
endmodule

>>> verif/sha1md_digest_monitor.sv
`timescale 1ns / 1ps

module sha1md_digest_monitor (
	input  logic  clk,
	input  logic  arst_n,
	sha1md_in_if  msg,
	sha1md_out_if digest,
	output int    mismatches,
	output int    digests_outstanding
);
	import sha1md_pkg::*;

	logic [31:0] hash_words [5];
	logic [7:0]  block_bytes [64];
	logic [63:0] bit_count;
	digest_t     expected_digests [$];
	int          error_total;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 5; i++)
			hash_words[i] = H_INIT[i];
		bit_count = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_words[0];
		b = hash_words[1];
		c = hash_words[2];
		d = hash_words[3];
		e = hash_words[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20)
				f = (b & c) | (~b & d);
			else if (i >= 40 && i < 60)
				f = (b & c) | (b & d) | (c & d);
			else
				f = b ^ c ^ d;
			t = rotl(a, 5) + f + e + ROUND_K[i / 20] + w[i];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_words[0] += a;
		hash_words[1] += b;
		hash_words[2] += c;
		hash_words[3] += d;
		hash_words[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] v);
		logic [5:0] pos;
		pos = bit_count[8:3];
		block_bytes[pos] = v;
		bit_count += 64'd8;
		if (pos == LAST_POS)
			compress_block();
	endfunction

	// pad, append the length and queue the resulting digest
	function automatic void finish_message();
		logic [63:0] length_bits;
		digest_t     result;
		length_bits = bit_count;
		absorb_byte(PAD_BYTE);
		while (bit_count[8:3] != LEN_POS)
			absorb_byte(8'h00);
		for (int i = 0; i < 8; i++)
			absorb_byte(length_bits[63 - 8*i -: 8]);
		for (int i = 0; i < 5; i++)
			result[i] = hash_words[i];
		expected_digests.push_back(result);
		restart_message();
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [31:0] got [5];
		digest_t     want;
		if (!arst_n) begin
			restart_message();
			expected_digests.delete();
			error_total = 0;
			mismatches <= 0;
			digests_outstanding <= 0;
		end else begin
			// compare the outgoing digest first: it can only belong to an older finish
			if (digest.valid && digest.ready) begin
				got = '{digest.digest_word0, digest.digest_word1, digest.digest_word2,
					digest.digest_word3, digest.digest_word4};
				if (expected_digests.size() == 0) begin
					$error("digest transaction with no expected digest pending");
					error_total++;
				end else begin
					want = expected_digests.pop_front();
					for (int i = 0; i < 5; i++)
						if (got[i] !== want[i]) begin
							$error("digest_word%0d: expected %h, actual %h", i, want[i], got[i]);
							error_total++;
						end
				end
			end
			if (msg.valid && msg.ready) begin
				case (msg.opcode)
					OP_ABSORB: begin
						absorb_byte(msg.message_byte);
					end
					OP_ABSORB_FINISH: begin
						absorb_byte(msg.message_byte);
						finish_message();
					end
					OP_FINISH: begin
						finish_message();
					end
					default: begin
					end
				endcase
			end
			mismatches <= error_total;
			digests_outstanding <= expected_digests.size();
		end
	end

endmodule

>>> verif/tb_sha1_message_digest_core.sv
`timescale 1ns / 1ps

module tb_sha1_message_digest_core;
	import sha1md_pkg::*;

	// The fourth opcode value is reserved; the core drops it without effect.
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// One receiver hold-off, long enough for the digest register to fill and a finish to back up.
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	// quiet: both sides stop idling. hold_requests: bump to ask for a hold-off.
	logic quiet;
	int   hold_requests;
	int   bytes_sent;
	int   mismatches;
	int   digests_outstanding;

	sha1md_in_if  msg_ch ();
	sha1md_out_if digest_ch ();

	sha1_message_digest_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	sha1md_digest_monitor digest_monitor (
		.clk                 (clk),
		.arst_n              (arst_n),
		.msg                 (msg_ch),
		.digest              (digest_ch),
		.mismatches          (mismatches),
		.digests_outstanding (digests_outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one transaction and hold it until the core takes it. Outside a
	// quiet stretch, drop valid for a random cycle now and then (about 11 in 100).
	task automatic offer(input logic [1:0] op, input logic [7:0] value);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid        <= 1'b1;
		msg_ch.opcode       <= op;
		msg_ch.message_byte <= value;
		do
			@(posedge clk);
		while (!msg_ch.ready);
		if (op != OP_RESERVED)
			bytes_sent++;
	endtask

	// Send one whole message of random content. End it either with a byte
	// that also finishes or with a bare finish; sprinkle reserved opcodes in
	// as noise, which must leave the hash state untouched.
	task automatic send_message(input int length);
		bit fold_last;
		fold_last = (length > 0) && $urandom_range(0, 1);
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(0, 99) < 3)
				offer(OP_RESERVED, 8'($urandom_range(0, 255)));
			if (fold_last && i == length - 1)
				offer(OP_ABSORB_FINISH, 8'($urandom_range(0, 255)));
			else
				offer(OP_ABSORB, 8'($urandom_range(0, 255)));
		end
		if (!fold_last)
			offer(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Mostly short messages so that digests come often; the rest sit at the
	// padding edges (55/56 bytes left room for the length or not, 63/64 fill
	// a block exactly) or span several blocks.
	function automatic int pick_length();
		int edges [12] = '{54, 55, 56, 57, 62, 63, 64, 65, 118, 119, 120, 128};
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $urandom_range(0, 8);
		if (sel < 9)
			return edges[$urandom_range(0, 11)];
		return $urandom_range(0, 140);
	endfunction

	// Receiver: accept with random stalls, stay open during quiet stretches,
	// and hold off for a long count when asked so the core backs up.
	initial begin
		int served;
		int stall_left;
		served = 0;
		stall_left = 0;
		digest_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				digest_ch.ready <= 1'b0;
			end else if (quiet)
				digest_ch.ready <= 1'b1;
			else
				digest_ch.ready <= ($urandom_range(0, 99) >= 11);
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		bytes_sent = 0;
		hold_requests <= 0;
		quiet <= 1'b0;
		msg_ch.valid <= 1'b0;
		msg_ch.opcode <= OP_ABSORB;
		msg_ch.message_byte <= 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, one-byte messages at both byte extremes,
		// "abc", reserved opcode mid-message and on an empty message, and
		// back-to-back finishes that each restart from the initial state.
		offer(OP_FINISH, 8'h00);
		offer(OP_ABSORB_FINISH, 8'h00);
		offer(OP_ABSORB_FINISH, 8'hFF);
		offer(OP_ABSORB, 8'h61);
		offer(OP_ABSORB, 8'h62);
		offer(OP_ABSORB_FINISH, 8'h63);
		offer(OP_ABSORB, 8'hFF);
		offer(OP_RESERVED, 8'hAA);
		offer(OP_ABSORB_FINISH, 8'h55);
		offer(OP_RESERVED, 8'h00);
		offer(OP_FINISH, 8'hFF);
		offer(OP_ABSORB, 8'h01);
		offer(OP_ABSORB, 8'h80);
		offer(OP_FINISH, 8'h7F);
		offer(OP_FINISH, 8'h00);
		offer(OP_FINISH, 8'hFF);

		// Random messages with idling on both sides.
		while (bytes_sent < 215)
			send_message(pick_length());

		// Stretch with no idling on either side.
		quiet <= 1'b1;
		while (bytes_sent < 330)
			send_message(pick_length());
		quiet <= 1'b0;

		// Hold off the receiver while short messages keep coming: the
		// digest register fills and the next finish must stall the input.
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < 8; i++)
			send_message($urandom_range(0, 4));

		while (bytes_sent < 505)
			send_message(pick_length());

		// Drain: let the last transaction register, then wait for every digest.
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (digests_outstanding != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog for a hung handshake or a digest that never arrives.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sha1_message_digest_core.f
sv/sha1md_pkg.sv
sv/sha1md_in_if.sv
sv/sha1md_out_if.sv
sv/sha1md_dp.sv
sv/sha1md_ctrl.sv
sv/sha1_message_digest_core.sv
verif/sha1md_digest_monitor.sv
verif/tb_sha1_message_digest_core.sv
